[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[sv/bmpd_pkg.sv]
// Types and constants of the bitmap pixel decoder.
`default_nettype none
package bmpd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_PIXEL,
        ST_SIGNATURE,
        ST_FORMAT,
        ST_DEPTH,
        ST_SIZE,
        ST_OVERLAP
    } t_status;

    // Header words, each held as four bytes, little endian.
    localparam int HDR_WORDS = 7;
    typedef logic [HDR_WORDS-1:0][3:0][7:0] t_hdr;

    localparam logic [2:0] HW_MAGIC       = 3'd0;
    localparam logic [2:0] HW_OFFSET      = 3'd1;
    localparam logic [2:0] HW_WIDTH       = 3'd2;
    localparam logic [2:0] HW_HEIGHT      = 3'd3;
    localparam logic [2:0] HW_PLANES_BPP  = 3'd4;
    localparam logic [2:0] HW_COMPRESSION = 3'd5;
    localparam logic [2:0] HW_COLORS      = 3'd6;

    localparam int          HDR_BYTES = 54;
    localparam logic [15:0] BMP_MAGIC = 16'h4D42;
    localparam int          PAL_DEPTH = 256;
    localparam int          PAL_W     = 24;
    localparam int          COORD_W   = 12;
    localparam int          CLR_W     = 8;

endpackage
`default_nettype wire

[sv/bmpd_ram.sv]
// Generic single write port RAM with registered read.
`default_nettype none
module bmpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[sv/bmpd_hdr_check.sv]
// Header validation and row geometry of the bitmap pixel decoder.
`default_nettype none
module bmpd_hdr_check #(
    parameter int MAX_DIM = 4096,
    localparam int DIM_W  = $clog2(MAX_DIM + 1),
    localparam int PB_W   = $clog2(4 * MAX_DIM + 1)
) (
    input  bmpd_pkg::t_hdr    i_hdr,
    output bmpd_pkg::t_status o_status,
    output bmpd_pkg::t_phase  o_next_phase,
    output logic [DIM_W-1:0]  o_width,
    output logic [DIM_W-1:0]  o_height,
    output logic [2:0]        o_bpx,
    output logic [PB_W-1:0]   o_pix_bytes,
    output logic [PB_W-1:0]   o_row_size,
    output logic [8:0]        o_colors,
    output logic [10:0]       o_pal_end
);
    import bmpd_pkg::*;

    logic [31:0]     w_magic;
    logic [31:0]     w_offset;
    logic [31:0]     w_w;
    logic [31:0]     w_h;
    logic [31:0]     w_pb;
    logic [31:0]     w_comp;
    logic [31:0]     w_colors;
    logic [15:0]     w_bpp;
    logic            w_depth_ok;
    logic [31:0]     w_end;
    logic [DIM_W-1:0] w_wd;
    logic [PB_W-1:0]  w_wx;
    logic [PB_W-1:0]  w_pix;

    assign w_magic  = i_hdr[HW_MAGIC];
    assign w_offset = i_hdr[HW_OFFSET];
    assign w_w      = i_hdr[HW_WIDTH];
    assign w_h      = i_hdr[HW_HEIGHT];
    assign w_pb     = i_hdr[HW_PLANES_BPP];
    assign w_comp   = i_hdr[HW_COMPRESSION];
    assign w_colors = i_hdr[HW_COLORS];
    assign w_bpp    = w_pb[31:16];

    assign w_depth_ok = (w_bpp == 16'd8) || (w_bpp == 16'd16) ||
                        (w_bpp == 16'd24) || (w_bpp == 16'd32);
    // Only meaningful once the palette count is within its limit.
    assign w_end = 32'(HDR_BYTES) + {w_colors[29:0], 2'b00};

    always_comb begin
        o_status     = ST_PIXEL;
        o_next_phase = PH_SKIP;
        if (w_magic[15:0] != BMP_MAGIC) begin
            o_status = ST_SIGNATURE;
        end else if (w_pb[15:0] != 16'd1 || w_comp != 32'd0) begin
            o_status = ST_FORMAT;
        end else if (!w_depth_ok || w_colors > 32'(PAL_DEPTH) ||
                     (w_bpp == 16'd8 && w_colors == 32'd0)) begin
            o_status = ST_DEPTH;
        end else if (w_w == 32'd0 || w_h == 32'd0 || w_w[31] || w_h[31] ||
                     w_w > 32'(MAX_DIM) || w_h > 32'(MAX_DIM)) begin
            o_status = ST_SIZE;
        end else if (w_offset < w_end) begin
            o_status = ST_OVERLAP;
        end
        if (w_colors != 32'd0) begin
            o_next_phase = PH_PALETTE;
        end else if (w_offset == 32'(HDR_BYTES)) begin
            o_next_phase = PH_PIXELS;
        end
    end

    // Bytes per pixel row: width times bytes per pixel, by shift and add.
    assign w_wd  = w_w[DIM_W-1:0];
    assign w_wx  = PB_W'(w_wd);
    assign o_bpx = w_bpp[5:3];

    always_comb begin
        case (o_bpx)
            3'd2:    w_pix = w_wx << 1;
            3'd3:    w_pix = w_wx + (w_wx << 1);
            3'd4:    w_pix = w_wx << 2;
            default: w_pix = w_wx;
        endcase
    end

    assign o_pix_bytes = w_pix;
    assign o_row_size  = (w_pix + PB_W'(3)) & ~PB_W'(3);
    assign o_width     = w_wd;
    assign o_height    = w_h[DIM_W-1:0];
    assign o_colors    = w_colors[8:0];
    assign o_pal_end   = w_end[10:0];

endmodule
`default_nettype wire

[sv/bitmap_file_pixel_decoder.sv]
// Top level of the bitmap file pixel decoder.
`default_nettype none
// Streams an uncompressed bitmap file in, one byte per word, and streams its
// pixels out. The 54-byte header is checked on its last byte (signature,
// single plane, no compression, depth of 8/16/24/32, palette count, size up
// to MAX_DIM, data offset past the palette); a failed check sends one error
// word (status != 0, color and coordinates zero, tlast set) and the rest of
// the file is dropped. The palette behind the header is written to a 256x24
// RAM, bytes up to the data offset are skipped, and every complete pixel
// gives one word: color, column and display row (row 0 at the top), tlast on
// the top-right pixel. Row padding and trailing bytes give nothing. 16-bit
// pixels come out as RGB555 with 5-bit components, not scaled. tuser on the
// input restarts the parse at any byte. One byte is taken every clock while
// the output is not stalled; a pixel word passes stage B, which waits on the
// palette RAM's registered read, and then the output register. There is no
// clearing pass after reset.
module bitmap_file_pixel_decoder #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] file_byte
    input  logic        i_s_axis_tuser,   // [0] first_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                          // [35:24] column, [47:36] display_row
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast    // last
);
    import bmpd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int PB_W  = $clog2(4 * MAX_DIM + 1);

    // parse state
    t_phase           r_phase, n_phase;
    logic [31:0]      r_pos, n_pos;
    t_hdr             r_hdr;

    // image geometry, loaded when the header passes
    logic [DIM_W-1:0] r_w, r_h;
    logic [2:0]       r_bpx;
    logic [PB_W-1:0]  r_pix_bytes, r_row_size;
    logic [8:0]       r_colors;
    logic [10:0]      r_pal_end;

    // header check results
    t_status          c_status;
    t_phase           c_next;
    logic [DIM_W-1:0] c_w, c_h;
    logic [2:0]       c_bpx;
    logic [PB_W-1:0]  c_pix, c_row;
    logic [8:0]       c_colors;
    logic [10:0]      c_pal_end;

    // pixel walk
    logic [PB_W-1:0]  r_rbc, n_rbc;
    logic [DIM_W-1:0] r_col, n_col, r_row, n_row;
    logic [1:0]       r_k, n_k;
    logic [2:0][7:0]  r_asm;
    logic [1:0][7:0]  r_pal_lo;

    // per-byte control
    logic             w_fire;
    logic             w_out_free;
    logic             w_b_move;
    logic [31:0]      w_p;
    logic [7:0]       w_v;
    logic [31:0]      w_p1;
    logic             hdr_we;
    logic [2:0]       hdr_e;
    logic [1:0]       hdr_lane;
    logic             geo_we;
    logic             asm_we;
    logic             pal_lo_we;
    logic [10:0]      w_rel;
    logic             pal_we;
    logic             pal_re;
    logic [PAL_W-1:0] pal_wdata;
    logic [PAL_W-1:0] pal_rdata;
    logic [7:0]       w_b0, w_b1, w_b2;
    logic [23:0]      w_c;
    logic             w_in_pix;
    logic             w_last;
    logic [DIM_W-1:0] w_disp;

    // result captured from the current byte
    logic             e_valid;
    t_status          e_status;
    logic             e_last;
    logic [7:0]       e_r, e_g, e_b;
    logic [COORD_W-1:0] e_col, e_row;
    logic             e_pal, e_pal_ok;

    // stage B: waits on the palette read
    logic             r_b_valid;
    t_status          r_b_status;
    logic             r_b_last;
    logic [7:0]       r_b_r, r_b_g, r_b_b;
    logic [COORD_W-1:0] r_b_col, r_b_row;
    logic             r_b_pal, r_b_pal_ok;

    // output register
    logic             r_o_valid;
    t_status          r_o_status;
    logic             r_o_last;
    logic [7:0]       r_o_r, r_o_g, r_o_b;
    logic [COORD_W-1:0] r_o_col, r_o_row;

    bmpd_hdr_check #(.MAX_DIM(MAX_DIM)) u_check (
        .i_hdr        (r_hdr),
        .o_status     (c_status),
        .o_next_phase (c_next),
        .o_width      (c_w),
        .o_height     (c_h),
        .o_bpx        (c_bpx),
        .o_pix_bytes  (c_pix),
        .o_row_size   (c_row),
        .o_colors     (c_colors),
        .o_pal_end    (c_pal_end)
    );

    bmpd_ram #(.WIDTH(PAL_W), .DEPTH(PAL_DEPTH)) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (pal_we),
        .i_wr_addr (w_rel[9:2]),
        .i_wr_data (pal_wdata),
        .i_rd_en   (pal_re),
        .i_rd_addr (w_v),
        .o_rd_data (pal_rdata)
    );

    // Handshake: the output register frees stage B, stage B frees the input.
    assign w_out_free      = !r_o_valid || i_m_axis_tready;
    assign w_b_move        = r_b_valid && w_out_free;
    assign o_s_axis_tready = !r_b_valid || w_out_free;
    assign w_fire          = i_s_axis_tvalid && o_s_axis_tready;

    assign w_v  = i_s_axis_tdata;
    assign w_p  = i_s_axis_tuser ? 32'd0 : r_pos;
    assign w_p1 = w_p + 32'd1;
    assign w_rel = w_p[10:0] - 11'(HDR_BYTES);
    assign pal_wdata = {w_v, r_pal_lo[1], r_pal_lo[0]};

    // pixel bytes: earlier ones from the assembly, the current one from the bus
    assign w_b0 = (r_k == 2'd0) ? w_v : r_asm[0];
    assign w_b1 = (r_k == 2'd1) ? w_v : r_asm[1];
    assign w_b2 = (r_k == 2'd2) ? w_v : r_asm[2];
    assign w_c  = {w_b2, w_b1, w_b0};

    assign w_in_pix = r_rbc < r_pix_bytes;
    assign w_last   = (r_row == r_h - DIM_W'(1)) && (r_col == r_w - DIM_W'(1));
    assign w_disp   = r_h - DIM_W'(1) - r_row;

    // Header capture slot: which word and byte lane this position feeds.
    always_comb begin
        hdr_we   = 1'b1;
        hdr_e    = HW_MAGIC;
        hdr_lane = w_p[1:0] - 2'd2;
        if (w_p < 32'd2) begin
            hdr_lane = w_p[1:0];
        end else if (w_p >= 32'd10 && w_p < 32'd14) begin
            hdr_e = HW_OFFSET;
        end else if (w_p >= 32'd18 && w_p < 32'd22) begin
            hdr_e = HW_WIDTH;
        end else if (w_p >= 32'd22 && w_p < 32'd26) begin
            hdr_e = HW_HEIGHT;
        end else if (w_p >= 32'd26 && w_p < 32'd30) begin
            hdr_e = HW_PLANES_BPP;
        end else if (w_p >= 32'd30 && w_p < 32'd34) begin
            hdr_e = HW_COMPRESSION;
        end else if (w_p >= 32'd46 && w_p < 32'd50) begin
            hdr_e = HW_COLORS;
        end else begin
            hdr_we = 1'b0;
        end
    end

    // Next state and result of the byte on the bus.
    always_comb begin
        n_phase   = i_s_axis_tuser ? PH_HEADER : r_phase;
        n_pos     = r_pos;
        n_rbc     = r_rbc;
        n_col     = r_col;
        n_row     = r_row;
        n_k       = r_k;
        geo_we    = 1'b0;
        asm_we    = 1'b0;
        pal_lo_we = 1'b0;
        pal_we    = 1'b0;
        pal_re    = 1'b0;
        e_valid   = 1'b0;
        e_status  = ST_PIXEL;
        e_last    = 1'b0;
        e_r       = '0;
        e_g       = '0;
        e_b       = '0;
        e_col     = '0;
        e_row     = '0;
        e_pal     = 1'b0;
        e_pal_ok  = 1'b0;

        case (n_phase)
            PH_HEADER: begin
                n_pos = w_p1;
                if (w_p == 32'(HDR_BYTES - 1)) begin
                    if (c_status != ST_PIXEL) begin
                        n_phase  = PH_DONE;
                        e_valid  = 1'b1;
                        e_status = c_status;
                        e_last   = 1'b1;
                    end else begin
                        n_phase = c_next;
                        geo_we  = 1'b1;
                        n_rbc   = '0;
                        n_col   = '0;
                        n_row   = '0;
                        n_k     = '0;
                    end
                end
            end
            PH_PALETTE: begin
                n_pos     = w_p1;
                pal_lo_we = (w_rel[1:0] == 2'd0) || (w_rel[1:0] == 2'd1);
                pal_we    = w_fire && (w_rel[1:0] == 2'd2);
                if (w_p1 == 32'(r_pal_end)) begin
                    n_phase = (r_hdr[HW_OFFSET] == w_p1) ? PH_PIXELS : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_pos = w_p1;
                if (w_p1 == r_hdr[HW_OFFSET]) begin
                    n_phase = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                if (w_in_pix) begin
                    asm_we = (r_k != 2'd3);
                    n_k    = (r_k == r_bpx[1:0] - 2'd1) ? 2'd0 : r_k + 2'd1;
                    if (r_k == r_bpx[1:0] - 2'd1) begin
                        e_valid = 1'b1;
                        e_last  = w_last;
                        e_col   = COORD_W'(r_col);
                        e_row   = COORD_W'(w_disp);
                        n_col   = r_col + DIM_W'(1);
                        case (r_bpx)
                            3'd1: begin
                                e_pal    = 1'b1;
                                e_pal_ok = {1'b0, w_v} < r_colors;
                                pal_re   = w_fire;
                            end
                            3'd2: begin
                                e_b = 8'(w_c[4:0]);
                                e_g = 8'(w_c[9:5]);
                                e_r = 8'(w_c[14:10]);
                            end
                            default: begin
                                e_b = w_c[7:0];
                                e_g = w_c[15:8];
                                e_r = w_c[23:16];
                            end
                        endcase
                    end
                end
                if (e_valid && w_last) begin
                    n_phase = PH_DONE;
                end else if ({1'b0, r_rbc} + (PB_W + 1)'(1) == {1'b0, r_row_size}) begin
                    n_rbc = '0;
                    n_col = '0;
                    n_row = r_row + DIM_W'(1);
                    n_k   = '0;
                end else begin
                    n_rbc = r_rbc + PB_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // parse control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_rbc   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_k     <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rbc   <= n_rbc;
            r_col   <= n_col;
            r_row   <= n_row;
            r_k     <= n_k;
        end
    end

    // header bytes, geometry and byte assembly
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (n_phase == PH_HEADER && hdr_we) begin
                r_hdr[hdr_e][hdr_lane] <= w_v;
            end
            if (geo_we) begin
                r_w         <= c_w;
                r_h         <= c_h;
                r_bpx       <= c_bpx;
                r_pix_bytes <= c_pix;
                r_row_size  <= c_row;
                r_colors    <= c_colors;
                r_pal_end   <= c_pal_end;
            end
            if (asm_we) begin
                r_asm[r_k] <= w_v;
            end
            if (pal_lo_we) begin
                r_pal_lo[w_rel[0]] <= w_v;
            end
        end
    end

    // stage B and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_b_valid <= e_valid;
            end else if (w_b_move) begin
                r_b_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && e_valid) begin
            r_b_status <= e_status;
            r_b_last   <= e_last;
            r_b_r      <= e_r;
            r_b_g      <= e_g;
            r_b_b      <= e_b;
            r_b_col    <= e_col;
            r_b_row    <= e_row;
            r_b_pal    <= e_pal;
            r_b_pal_ok <= e_pal_ok;
        end
        if (w_b_move) begin
            r_o_status <= r_b_status;
            r_o_last   <= r_b_last;
            r_o_col    <= r_b_col;
            r_o_row    <= r_b_row;
            if (r_b_pal) begin
                // index past the palette count reads as black
                r_o_r <= r_b_pal_ok ? pal_rdata[23:16] : '0;
                r_o_g <= r_b_pal_ok ? pal_rdata[15:8]  : '0;
                r_o_b <= r_b_pal_ok ? pal_rdata[7:0]   : '0;
            end else begin
                r_o_r <= r_b_r;
                r_o_g <= r_b_g;
                r_o_b <= r_b_b;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_row, r_o_col, r_o_b, r_o_g, r_o_r};
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tlast  = r_o_last;

endmodule
`default_nettype wire

[sv/bmpd_checker.sv]
// Port-level checks of the bitmap pixel decoder, bound to its top level.
`default_nettype none
`include "assert_macros.svh"
module bmpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // a stalled output word holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid &&
        $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast),
        "output word changed while stalled")

    // an error word is blank and closes the image
    `ASSERT_NEVER(a_err_form, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser != 3'd0 &&
        (!o_m_axis_tlast || o_m_axis_tdata != 48'd0),
        "error word carries data or lacks tlast")

    // an empty output stage never holds back the input
    `ASSERT_CLK(a_ready_empty, i_clk, i_rst_n,
        !o_m_axis_tvalid |-> o_s_axis_tready,
        "input stalled with empty output")

    // nothing comes out right after reset
    `ASSERT_CLK(a_quiet_reset, i_clk, i_rst_n,
        $past(!i_rst_n) |-> !o_m_axis_tvalid,
        "output valid right after reset")

endmodule

bind bitmap_file_pixel_decoder bmpd_checker u_bmpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

[test/bitmap_file_pixel_decoder_test.sv]
// Self-checking stream testbench for the bitmap file pixel decoder.
module bitmap_file_pixel_decoder_test;
    import bmpd_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int TAIL_WORDS   = 300;       // last words go out with no idling on either side
    localparam int RANDOM_WORDS = 400;
    localparam int HOLD_AT      = 200;       // result count that starts the long output hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;        // output passes stage B and the output register; leave margin
    localparam int REPORT_MAX   = 40;

    // One input word: a file byte and the restart flag that rides on tuser.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_file_word;

    // One output word, field by field.
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] display_row;
        t_status     status;
        logic        last;
    } t_pixel_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] file_byte
    logic        s_tuser = 1'b0;    // [0] first_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [7:0] red, [15:8] green, [23:16] blue,
                                    // [35:24] column, [47:36] display_row
    logic [2:0]  m_tuser;           // [2:0] status
    logic        m_tlast;

    bitmap_file_pixel_decoder #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Words still to be sent, and pixel words still to arrive.
    t_file_word  file_stream [$];
    t_pixel_word pixel_expect [$];
    int          errors = 0;
    int          reports = 0;

    // Decoder state as the predictor sees it.
    logic [31:0] file_pos = '0;
    logic [31:0] hdr_word [HDR_WORDS] = '{default: '0};
    logic [23:0] pal [PAL_DEPTH];
    logic [23:0] px_bytes = '0;
    logic [31:0] col_cnt = '0;
    logic [31:0] row_cnt = '0;
    logic [31:0] row_bytes = '0;
    t_phase      phase = PH_HEADER;

    // Advance the decoder by one accepted byte; queue the pixel or error word it yields.
    task automatic decode_byte(input logic [7:0] v, input logic first);
        logic [31:0] p, w, h, colors, offset, bpp, bpx, row_size, k, rel;
        logic [23:0] entry;
        t_status     st;
        t_pixel_word px;
        p = file_pos;
        if (first) begin
            file_pos = '0;
            p = '0;
            for (int i = 0; i < HDR_WORDS; i++) hdr_word[i] = '0;
            px_bytes = '0;
            col_cnt = '0;
            row_cnt = '0;
            row_bytes = '0;
            phase = PH_HEADER;
        end
        case (phase)
            PH_HEADER: begin
                // Only the fields the decoder uses are kept, little endian.
                if (p < 2) hdr_word[HW_MAGIC][8*p +: 8] = v;
                else if (p >= 10 && p < 14) hdr_word[HW_OFFSET][8*(p-10) +: 8] = v;
                else if (p >= 18 && p < 22) hdr_word[HW_WIDTH][8*(p-18) +: 8] = v;
                else if (p >= 22 && p < 26) hdr_word[HW_HEIGHT][8*(p-22) +: 8] = v;
                else if (p >= 26 && p < 30) hdr_word[HW_PLANES_BPP][8*(p-26) +: 8] = v;
                else if (p >= 30 && p < 34) hdr_word[HW_COMPRESSION][8*(p-30) +: 8] = v;
                else if (p >= 46 && p < 50) hdr_word[HW_COLORS][8*(p-46) +: 8] = v;
                file_pos = p + 1;
                if (p == HDR_BYTES - 1) begin
                    w = hdr_word[HW_WIDTH];
                    h = hdr_word[HW_HEIGHT];
                    bpp = hdr_word[HW_PLANES_BPP][31:16];
                    colors = hdr_word[HW_COLORS];
                    offset = hdr_word[HW_OFFSET];
                    st = ST_PIXEL;
                    if (hdr_word[HW_MAGIC][15:0] != BMP_MAGIC)
                        st = ST_SIGNATURE;
                    else if (hdr_word[HW_PLANES_BPP][15:0] != 1 || hdr_word[HW_COMPRESSION] != 0)
                        st = ST_FORMAT;
                    else if ((bpp != 8 && bpp != 16 && bpp != 24 && bpp != 32) ||
                             colors > PAL_DEPTH || (bpp == 8 && colors == 0))
                        st = ST_DEPTH;
                    else if (w == 0 || h == 0 || w[31] || h[31] || w > MAX_DIM || h > MAX_DIM)
                        st = ST_SIZE;
                    else if (offset < HDR_BYTES + 4 * colors)
                        st = ST_OVERLAP;
                    if (st != ST_PIXEL) begin
                        // error word: everything zero but status and last
                        phase = PH_DONE;
                        px = '0;
                        px.status = st;
                        px.last = 1'b1;
                        pixel_expect.push_back(px);
                    end else if (colors != 0) begin
                        phase = PH_PALETTE;
                    end else if (offset == HDR_BYTES) begin
                        phase = PH_PIXELS;
                    end else begin
                        phase = PH_SKIP;
                    end
                end
            end
            PH_PALETTE: begin
                // BGRA entries; alpha is dropped
                rel = p - HDR_BYTES;
                if (rel[1:0] == 2'd0) pal[rel[9:2]] = {16'h0, v};
                else if (rel[1:0] == 2'd1) pal[rel[9:2]][15:8] = v;
                else if (rel[1:0] == 2'd2) pal[rel[9:2]][23:16] = v;
                file_pos = p + 1;
                if (file_pos == HDR_BYTES + 4 * hdr_word[HW_COLORS])
                    phase = (hdr_word[HW_OFFSET] == file_pos) ? PH_PIXELS : PH_SKIP;
            end
            PH_SKIP: begin
                file_pos = p + 1;
                if (file_pos == hdr_word[HW_OFFSET]) phase = PH_PIXELS;
            end
            PH_PIXELS: begin
                w = hdr_word[HW_WIDTH];
                h = hdr_word[HW_HEIGHT];
                bpp = hdr_word[HW_PLANES_BPP][31:16];
                bpx = bpp >> 3;
                row_size = ((w * bpp + 31) >> 5) << 2;
                if (row_bytes < w * bpx) begin
                    k = row_bytes % bpx;
                    if (k == 0) px_bytes = '0;
                    if (k < 3) px_bytes[8*k +: 8] = v;
                    if (k == bpx - 1) begin
                        px = '0;
                        if (bpp == 8) begin
                            // indices past the palette count read as black
                            entry = (px_bytes < hdr_word[HW_COLORS]) ? pal[px_bytes[7:0]] : '0;
                            px.red = entry[23:16];
                            px.green = entry[15:8];
                            px.blue = entry[7:0];
                        end else if (bpp == 16) begin
                            px.red = {3'b0, px_bytes[14:10]};
                            px.green = {3'b0, px_bytes[9:5]};
                            px.blue = {3'b0, px_bytes[4:0]};
                        end else begin
                            px.red = px_bytes[23:16];
                            px.green = px_bytes[15:8];
                            px.blue = px_bytes[7:0];
                        end
                        px.column = col_cnt[11:0];
                        px.display_row = 12'(h - 1 - row_cnt);
                        px.status = ST_PIXEL;
                        px.last = (row_cnt == h - 1 && col_cnt == w - 1);
                        pixel_expect.push_back(px);
                        col_cnt = col_cnt + 1;
                        if (px.last) phase = PH_DONE;
                    end
                end
                if (phase == PH_PIXELS) begin
                    row_bytes = row_bytes + 1;
                    if (row_bytes >= row_size) begin
                        row_bytes = '0;
                        col_cnt = '0;
                        row_cnt = row_cnt + 1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Build one file and append it to the send queue. keep >= 0 cuts the file after keep bytes.
    task automatic add_bitmap(input logic [15:0] magic, input logic [31:0] offset,
                              input logic [31:0] width, input logic [31:0] height,
                              input logic [15:0] planes, input logic [15:0] bpp,
                              input logic [31:0] compression, input logic [31:0] colors,
                              input logic restart, input int keep);
        logic [7:0]  b [$];
        logic [31:0] row_size, used, pick;
        int          n;
        t_file_word  fw;
        // unused header fields stay random
        for (int i = 0; i < HDR_BYTES; i++) b.push_back($urandom_range(0, 255));
        for (int i = 0; i < 4; i++) begin
            if (i < 2) begin
                b[i] = magic[8*i +: 8];
                b[26+i] = planes[8*i +: 8];
                b[28+i] = bpp[8*i +: 8];
            end
            b[10+i] = offset[8*i +: 8];
            b[18+i] = width[8*i +: 8];
            b[22+i] = height[8*i +: 8];
            b[30+i] = compression[8*i +: 8];
            b[46+i] = colors[8*i +: 8];
        end
        if (colors <= PAL_DEPTH) repeat (4 * colors) b.push_back($urandom_range(0, 255));
        n = 0;
        while (b.size() < offset && n < 64) begin
            b.push_back($urandom_range(0, 255));
            n++;
        end
        if (width >= 1 && width <= MAX_DIM && height >= 1 && height <= MAX_DIM &&
            (bpp == 8 || bpp == 16 || bpp == 24 || bpp == 32)) begin
            row_size = ((width * bpp + 31) >> 5) << 2;
            used = width * (bpp >> 3);
            repeat (height) begin
                for (int j = 0; j < row_size; j++) begin
                    if (bpp == 8 && j < used) begin
                        pick = $urandom_range(0, colors);
                        b.push_back((pick > 255) ? 8'hFF : pick[7:0]);
                    end else begin
                        b.push_back($urandom_range(0, 255));
                    end
                end
            end
        end else begin
            repeat (4) b.push_back($urandom_range(0, 255));
        end
        repeat ($urandom_range(0, 3)) b.push_back($urandom_range(0, 255));
        if (keep >= 0) while (b.size() > keep) void'(b.pop_back());
        foreach (b[i]) begin
            fw.data = b[i];
            fw.first = (i == 0) ? restart : 1'b0;
            file_stream.push_back(fw);
        end
    endtask

    // Sender: offers queued words, with random idle bursts except near the end.
    int         send_gap = 0;
    t_file_word next_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (file_stream.size() > 0 &&
                             (file_stream.size() < TAIL_WORDS || $urandom_range(0, 9) != 0)) begin
                    next_word = file_stream.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_word.data;
                    s_tuser <= next_word.first;
                end else begin
                    // random idle burst, starting now
                    s_tvalid <= 1'b0;
                    if (file_stream.size() > 0) send_gap <= $urandom_range(0, 6);
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
        if (want !== got) begin
            errors++;
            if (reports < REPORT_MAX) begin
                reports++;
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        end
    endtask

    // Receiver: checks each word against the oldest expectation; random stalls,
    // plus one long hold-off that backs the decoder up into its input.
    int          recv_gap = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          results_seen = 0;
    t_pixel_word want_px;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pixel_expect.size() == 0) begin
                    errors++;
                    if (reports < REPORT_MAX) begin
                        reports++;
                        $display("%0t: word with nothing expected, expected none got %h/%0d/%b",
                                 $time, m_tdata, m_tuser, m_tlast);
                    end
                end else begin
                    want_px = pixel_expect.pop_front();
                    check_field("red", want_px.red, m_tdata[7:0]);
                    check_field("green", want_px.green, m_tdata[15:8]);
                    check_field("blue", want_px.blue, m_tdata[23:16]);
                    check_field("column", want_px.column, m_tdata[35:24]);
                    check_field("display_row", want_px.display_row, m_tdata[47:36]);
                    check_field("status", want_px.status, m_tuser);
                    check_field("last", want_px.last, m_tlast);
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (file_stream.size() >= TAIL_WORDS && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    int          rand_files;
    int          queued;
    int          kind;
    logic [15:0] magic, planes, bpp;
    logic [31:0] offset, width, height, compression, colors;
    int          keep;

    initial begin
        // Directed files. The first one carries no restart flag: reset already
        // leaves the parse at byte 0.
        add_bitmap(BMP_MAGIC, 54, 3, 2, 1, 24, 0, 0, 1'b0, -1);
        add_bitmap(BMP_MAGIC, 70, 4, 3, 1, 8, 0, 4, 1'b1, -1);   // index past palette possible
        add_bitmap(BMP_MAGIC, 60, 3, 2, 1, 16, 0, 0, 1'b1, -1);  // gap, no palette
        add_bitmap(BMP_MAGIC, 67, 2, 2, 1, 32, 0, 2, 1'b1, -1);  // unused palette, then gap
        add_bitmap(16'h4D43, 54, 2, 2, 1, 24, 0, 0, 1'b1, -1);   // bad signature
        add_bitmap(BMP_MAGIC, 54, 2, 2, 2, 24, 0, 0, 1'b1, -1);  // two planes
        add_bitmap(BMP_MAGIC, 54, 2, 2, 1, 24, 1, 0, 1'b1, -1);  // compressed
        add_bitmap(BMP_MAGIC, 54, 2, 2, 1, 4, 0, 0, 1'b1, -1);   // depth not decoded
        add_bitmap(BMP_MAGIC, 54, 2, 2, 1, 8, 0, 0, 1'b1, -1);   // 8-bit with no palette
        add_bitmap(BMP_MAGIC, 1082, 2, 2, 1, 24, 0, 257, 1'b1, -1); // palette too big
        add_bitmap(BMP_MAGIC, 54, 0, 2, 1, 24, 0, 0, 1'b1, -1);  // zero width
        add_bitmap(BMP_MAGIC, 54, 2, 32'h8000_0001, 1, 24, 0, 0, 1'b1, -1); // negative height
        add_bitmap(BMP_MAGIC, 54, MAX_DIM + 1, 1, 1, 24, 0, 0, 1'b1, -1);   // too wide
        add_bitmap(BMP_MAGIC, 65, 2, 2, 1, 8, 0, 3, 1'b1, -1);   // data starts inside palette
        add_bitmap(BMP_MAGIC, 54, 2, 2, 1, 24, 0, 0, 1'b1, 30);  // header cut short
        add_bitmap(BMP_MAGIC, 54, 5, 4, 1, 24, 0, 0, 1'b1, 74);  // cut inside pixel data
        add_bitmap(BMP_MAGIC, 32'hFFFF_FFF0, 2, 2, 1, 24, 0, 0, 1'b1, -1); // offset never reached
        add_bitmap(BMP_MAGIC, 1078, MAX_DIM, 1, 1, 8, 0, 256, 1'b1, -1);   // widest, full palette
        add_bitmap(BMP_MAGIC, 54, 1, MAX_DIM, 1, 32, 0, 0, 1'b1, -1);      // tallest
        add_bitmap(BMP_MAGIC, 58, 1, 1, 1, 8, 0, 1, 1'b1, -1);   // single pixel

        // Random files: mostly well formed with random content, some broken.
        queued = file_stream.size();
        rand_files = 0;
        while (file_stream.size() - queued < RANDOM_WORDS || rand_files < 8) begin
            case ($urandom_range(0, 3))
                0: bpp = 8;
                1: bpp = 16;
                2: bpp = 24;
                default: bpp = 32;
            endcase
            width = $urandom_range(1, 9);
            height = $urandom_range(1, 6);
            if (bpp == 8) colors = ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(1, 6);
            else colors = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
            offset = HDR_BYTES + 4 * colors + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6));
            magic = BMP_MAGIC;
            planes = 1;
            compression = 0;
            keep = -1;
            kind = $urandom_range(0, 19);
            case (kind)
                0: magic = magic ^ (16'h1 << $urandom_range(0, 15));
                1: begin
                    planes = $urandom_range(0, 65535);
                    if (planes == 1) planes = 0;
                end
                2: begin
                    compression = $urandom;
                    if (compression == 0) compression = 1;
                end
                3: begin
                    bpp = $urandom_range(0, 65535);
                    if (bpp == 8 || bpp == 16 || bpp == 24 || bpp == 32) bpp = bpp + 1;
                end
                4: case ($urandom_range(0, 2))
                    0: width = 0;
                    1: height = $urandom_range(MAX_DIM + 1, 2 * MAX_DIM);
                    default: width = $urandom | 32'h8000_0000;
                endcase
                5: offset = $urandom_range(0, HDR_BYTES + 4 * colors - 1);
                6: keep = $urandom_range(1, 100);
                default: ;
            endcase
            add_bitmap(magic, offset, width, height, planes, bpp, compression, colors, 1'b1, keep);
            rand_files++;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (file_stream.size() != 0 || s_tvalid) @(posedge i_clk);
        while (pixel_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pixel_expect.size() == 0) begin
            $display("bitmap_file_pixel_decoder verification clean");
        end else begin
            $display("bitmap_file_pixel_decoder verification failed");
        end
        $finish;
    end

    // Run limit, well past the slowest legal run.
    initial begin
        #20_000_000;
        $display("bitmap_file_pixel_decoder verification failed");
        $finish;
    end

endmodule
